### rtl/core/stick_position_yaw_setpoint_core_defines.svh
// Assertion macros for the stick position and yaw setpoint core.
// Expects signals named clock and reset in the scope of use.
`ifndef STICK_POSITION_YAW_SETPOINT_CORE_DEFINES_SVH
`define STICK_POSITION_YAW_SETPOINT_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define SPY_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset
`define SPY_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/spy_pkg.sv
// Package for the stick position and yaw setpoint core.
// Word types, register codes, reset values and saturation helper; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package spy_pkg;

   localparam int RATE_W   = 22;
   localparam int ERR_W    = 26;
   localparam int STICK_W  = 16;
   localparam int POS_W    = 32;
   localparam int CSR_W    = 26;
   localparam int CSR_IDX_W = 3;
   localparam int AXIS_W   = 2;

   localparam logic [RATE_W-1:0]  RATE_RESET = RATE_W'(65536);
   localparam logic [ERR_W-1:0]   ERR_RESET  = ERR_W'(65536);
   localparam logic [STICK_W-1:0] DZ_LOW_RESET  = 16'hF333;  // -3277
   localparam logic [STICK_W-1:0] DZ_HIGH_RESET = 16'h0CCD;  //  3277

   typedef enum logic [0:0] {
      OP_UPDATE = 1'b0,
      OP_LOAD   = 1'b1
   } opcode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAX_HORIZONTAL_RATE  = 3'd0,
      CSR_MAX_VERTICAL_RATE    = 3'd1,
      CSR_MAX_TURN_RATE        = 3'd2,
      CSR_MAX_HORIZONTAL_ERROR = 3'd3,
      CSR_MAX_VERTICAL_ERROR   = 3'd4,
      CSR_MAX_HEADING_ERROR    = 3'd5,
      CSR_DEAD_ZONE_LOW        = 3'd6,
      CSR_DEAD_ZONE_HIGH       = 3'd7
   } csr_index_type;

   typedef enum logic [AXIS_W-1:0] {
      AXIS_X       = 2'd0,
      AXIS_Y       = 2'd1,
      AXIS_Z       = 2'd2,
      AXIS_HEADING = 2'd3
   } axis_type;

   typedef struct packed {
      logic                       opcode;
      logic signed [STICK_W-1:0]  stick_pitch;
      logic signed [STICK_W-1:0]  stick_roll;
      logic signed [STICK_W-1:0]  stick_yaw;
      logic        [STICK_W-1:0]  stick_thrust;
      logic        [STICK_W-1:0]  elapsed;
      logic signed [POS_W-1:0]    meas_x;
      logic signed [POS_W-1:0]    meas_y;
      logic signed [POS_W-1:0]    meas_z;
      logic signed [POS_W-1:0]    meas_heading;
   } req_type;

   typedef struct packed {
      logic signed [POS_W-1:0] cmd_x_out;
      logic signed [POS_W-1:0] cmd_y_out;
      logic signed [POS_W-1:0] cmd_z_out;
      logic signed [POS_W-1:0] cmd_heading_out;
   } rsp_type;

   // Controller to datapath commands
   typedef struct packed {
      logic     load_meas;  // copy measurement into command
      logic     capture;    // latch the update word
      logic     mul_dt;     // stick times elapsed
      logic     mul_rate;   // times axis rate
      logic     add_delta;  // command plus delta, saturated
      logic     clamp;      // clamp and write back
      logic     publish;    // copy command to output register
      axis_type axis;
   } ctrl_cmd_type;

   // Saturate a 34-bit signed sum to 32 bits
   function automatic logic signed [POS_W-1:0] sat32(input logic signed [POS_W+1:0] v);
      logic signed [POS_W-1:0] r;
      if ((v[POS_W+1] == v[POS_W]) && (v[POS_W] == v[POS_W-1])) begin
         r = v[POS_W-1:0];
      end else begin
         r = {v[POS_W+1], {(POS_W-1){~v[POS_W+1]}}};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### rtl/core/spy_ctrl.sv
// Sequencing controller for the setpoint core.
// Walks four axes through a four-step schedule; uses spy_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spy_ctrl
   import spy_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   req_valid,
   input  wire logic   req_is_load,
   output logic        req_ready,
   output logic        rsp_valid,
   input  wire logic   rsp_ready,
   output ctrl_cmd_type cmd
);

   typedef enum logic [5:0] {
      ST_IDLE     = 6'b000001,
      ST_MUL_DT   = 6'b000010,
      ST_MUL_RATE = 6'b000100,
      ST_ADD      = 6'b001000,
      ST_CLAMP    = 6'b010000,
      ST_DONE     = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   axis_type  axis_ff, axis_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      axis_in  = axis_ff;
      cmd      = '0;
      cmd.axis = axis_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_is_load) begin
                  cmd.load_meas = 1'b1;
               end else begin
                  cmd.capture = 1'b1;
                  axis_in     = AXIS_X;
                  state_in    = ST_MUL_DT;
               end
            end
         end
         ST_MUL_DT: begin
            cmd.mul_dt = 1'b1;
            state_in   = ST_MUL_RATE;
         end
         ST_MUL_RATE: begin
            cmd.mul_rate = 1'b1;
            state_in     = ST_ADD;
         end
         ST_ADD: begin
            cmd.add_delta = 1'b1;
            state_in      = ST_CLAMP;
         end
         ST_CLAMP: begin
            cmd.clamp = 1'b1;
            if (axis_ff == AXIS_HEADING) begin
               state_in = ST_DONE;
            end else begin
               axis_in  = axis_type'(axis_ff + 2'd1);
               state_in = ST_MUL_DT;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         axis_ff      <= AXIS_X;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

### rtl/core/spy_datapath.sv
// Datapath for the setpoint core: control registers, command state,
// shared two-step multiplier, saturating add and clamp. Uses spy_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spy_datapath
   import spy_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire ctrl_cmd_type         cmd,
   input  wire req_type              req_data,
   input  wire logic                 csr_write_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_wdata,
   output rsp_type                   rsp_data
);

   // Control registers
   logic [RATE_W-1:0]  h_rate_ff, v_rate_ff, turn_rate_ff;
   logic [ERR_W-1:0]   h_err_ff, v_err_ff, head_err_ff;
   logic [STICK_W-1:0] dz_low_ff, dz_high_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         h_rate_ff    <= RATE_RESET;
         v_rate_ff    <= RATE_RESET;
         turn_rate_ff <= RATE_RESET;
         h_err_ff     <= ERR_RESET;
         v_err_ff     <= ERR_RESET;
         head_err_ff  <= ERR_RESET;
         dz_low_ff    <= DZ_LOW_RESET;
         dz_high_ff   <= DZ_HIGH_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_MAX_HORIZONTAL_RATE:  h_rate_ff    <= csr_wdata[RATE_W-1:0];
            CSR_MAX_VERTICAL_RATE:    v_rate_ff    <= csr_wdata[RATE_W-1:0];
            CSR_MAX_TURN_RATE:        turn_rate_ff <= csr_wdata[RATE_W-1:0];
            CSR_MAX_HORIZONTAL_ERROR: h_err_ff     <= csr_wdata[ERR_W-1:0];
            CSR_MAX_VERTICAL_ERROR:   v_err_ff     <= csr_wdata[ERR_W-1:0];
            CSR_MAX_HEADING_ERROR:    head_err_ff  <= csr_wdata[ERR_W-1:0];
            CSR_DEAD_ZONE_LOW:        dz_low_ff    <= csr_wdata[STICK_W-1:0];
            CSR_DEAD_ZONE_HIGH:       dz_high_ff   <= csr_wdata[STICK_W-1:0];
            default: ;
         endcase
      end
   end

   // Latched update word
   req_type word_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         word_ff <= req_data;
      end
   end

   // Axis operand selection
   logic [STICK_W-1:0]        stick_raw;
   logic signed [STICK_W:0]   stick_sel;
   logic                      use_dz;
   logic [RATE_W-1:0]         rate_sel;
   logic [ERR_W-1:0]          err_sel;
   logic signed [POS_W-1:0]   meas_sel;
   logic [STICK_W-1:0]        thr;

   assign thr = word_ff.stick_thrust;

   always_comb begin
      stick_raw = word_ff.stick_pitch;
      stick_sel = {word_ff.stick_pitch[STICK_W-1], word_ff.stick_pitch};
      use_dz    = 1'b1;
      rate_sel  = h_rate_ff;
      err_sel   = h_err_ff;
      meas_sel  = word_ff.meas_x;
      case (cmd.axis)
         AXIS_X: begin
            stick_raw = word_ff.stick_pitch;
            stick_sel = {word_ff.stick_pitch[STICK_W-1], word_ff.stick_pitch};
            rate_sel  = h_rate_ff;
            err_sel   = h_err_ff;
            meas_sel  = word_ff.meas_x;
         end
         AXIS_Y: begin
            // roll drives negative y; full negative deflection negates exactly
            stick_raw = word_ff.stick_roll;
            stick_sel = -$signed({word_ff.stick_roll[STICK_W-1], word_ff.stick_roll});
            rate_sel  = h_rate_ff;
            err_sel   = h_err_ff;
            meas_sel  = word_ff.meas_y;
         end
         AXIS_Z: begin
            // thrust re-centred: 0 -> full down, 1.0 -> full up
            stick_raw = thr;
            stick_sel = {~thr[STICK_W-1], ~thr[STICK_W-1], thr[STICK_W-2:0]};
            use_dz    = 1'b0;
            rate_sel  = v_rate_ff;
            err_sel   = v_err_ff;
            meas_sel  = word_ff.meas_z;
         end
         AXIS_HEADING: begin
            stick_raw = word_ff.stick_yaw;
            stick_sel = {word_ff.stick_yaw[STICK_W-1], word_ff.stick_yaw};
            rate_sel  = turn_rate_ff;
            err_sel   = head_err_ff;
            meas_sel  = word_ff.meas_heading;
         end
         default: ;
      endcase
   end

   logic in_dz;
   assign in_dz = use_dz
                  && ($signed(stick_raw) >= $signed(dz_low_ff))
                  && ($signed(stick_raw) <= $signed(dz_high_ff));

   // Step 1: stick times elapsed, plus clamp bounds
   logic signed [2*STICK_W+1:0] prod_dt_ff, prod_dt_in, prod_dt_raw;
   logic signed [POS_W-1:0]     lo_ff, hi_ff;
   logic signed [POS_W+1:0]     lo_sum, hi_sum;

   // signed product kept apart from the dead-zone mux
   assign prod_dt_raw = stick_sel * $signed({1'b0, word_ff.elapsed});
   assign prod_dt_in  = in_dz ? '0 : prod_dt_raw;
   assign lo_sum = $signed({{2{meas_sel[POS_W-1]}}, meas_sel})
                 - $signed({{(POS_W+2-ERR_W){1'b0}}, err_sel});
   assign hi_sum = $signed({{2{meas_sel[POS_W-1]}}, meas_sel})
                 + $signed({{(POS_W+2-ERR_W){1'b0}}, err_sel});

   always_ff @(posedge clock) begin
      if (cmd.mul_dt) begin
         prod_dt_ff <= prod_dt_in;
         lo_ff      <= sat32(lo_sum);
         hi_ff      <= sat32(hi_sum);
      end
   end

   // Step 2: times axis rate; floor by arithmetic shift of 31
   localparam int PROD_W  = 2*STICK_W + 2 + RATE_W + 1;
   localparam int DELTA_W = PROD_W - 31;

   logic signed [PROD_W-1:0]  prod_rate_ff;
   logic signed [DELTA_W-1:0] delta;

   always_ff @(posedge clock) begin
      if (cmd.mul_rate) begin
         prod_rate_ff <= prod_dt_ff * $signed({1'b0, rate_sel});
      end
   end

   assign delta = prod_rate_ff[PROD_W-1:31];

   // Command state
   logic signed [POS_W-1:0] cmd_ff [4];
   logic signed [POS_W-1:0] cmd_sel;
   logic signed [POS_W+1:0] add_sum;
   logic signed [POS_W-1:0] adv_ff;
   logic signed [POS_W-1:0] clamped;

   assign cmd_sel = cmd_ff[cmd.axis];
   assign add_sum = $signed({{2{cmd_sel[POS_W-1]}}, cmd_sel})
                  + $signed({{(POS_W+2-DELTA_W){delta[DELTA_W-1]}}, delta});

   // Step 3: saturating add
   always_ff @(posedge clock) begin
      if (cmd.add_delta) begin
         adv_ff <= sat32(add_sum);
      end
   end

   // Step 4: clamp into [meas - err, meas + err]
   always_comb begin
      clamped = adv_ff;
      if (adv_ff < lo_ff) begin
         clamped = lo_ff;
      end
      if (clamped > hi_ff) begin
         clamped = hi_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff[AXIS_X]       <= '0;
         cmd_ff[AXIS_Y]       <= '0;
         cmd_ff[AXIS_Z]       <= '0;
         cmd_ff[AXIS_HEADING] <= '0;
      end else if (cmd.load_meas) begin
         cmd_ff[AXIS_X]       <= req_data.meas_x;
         cmd_ff[AXIS_Y]       <= req_data.meas_y;
         cmd_ff[AXIS_Z]       <= req_data.meas_z;
         cmd_ff[AXIS_HEADING] <= req_data.meas_heading;
      end else if (cmd.clamp) begin
         cmd_ff[cmd.axis] <= clamped;
      end
   end

   // Output register
   rsp_type out_ff;

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         out_ff.cmd_x_out       <= cmd_ff[AXIS_X];
         out_ff.cmd_y_out       <= cmd_ff[AXIS_Y];
         out_ff.cmd_z_out       <= cmd_ff[AXIS_Z];
         out_ff.cmd_heading_out <= cmd_ff[AXIS_HEADING];
      end
   end

   assign rsp_data = out_ff;

endmodule

`default_nettype wire

### rtl/core/stick_position_yaw_setpoint_core.sv
// Stick position and yaw setpoint core. An update word (opcode 0) has its
// result in the output register once the schedule is through: the word is latched
// at the accepting edge, then four steps for each of the four axes run through
// one shared multiplier path (stick x elapsed, x rate, saturating add, clamp),
// then the done state publishes once the output register is free to take it.
// The next word is accepted only after the publish, when the core is back in
// idle, so a new update cannot start before the last one is through.
// A load word (opcode 1) copies the measured fields into the command in the
// cycle it is accepted and returns no result. The next word is taken while a
// result still waits in the output register. Control registers are to be written
// through the csr_ port only while the core is idle; the core does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

`include "stick_position_yaw_setpoint_core_defines.svh"

module stick_position_yaw_setpoint_core
   import spy_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire req_type              req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output rsp_type                   rsp_data,
   input  wire logic                 csr_write_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_wdata
);

   ctrl_cmd_type cmd;
   logic         req_is_load;

   assign req_is_load = (req_data.opcode == OP_LOAD);

   spy_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_is_load (req_is_load),
      .req_ready   (req_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .cmd         (cmd)
   );

   spy_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .req_data     (req_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .rsp_data     (rsp_data)
   );

   // Only one datapath step is commanded per cycle
   `SPY_ASSERT_NOW(a_one_step, 1'b1, $onehot0({cmd.load_meas, cmd.capture, cmd.mul_dt, cmd.mul_rate, cmd.add_delta, cmd.clamp, cmd.publish}), "more than one datapath step")

   // Working steps never overlap with accepting a word
   `SPY_ASSERT_NOW(a_busy_not_ready, cmd.mul_dt || cmd.mul_rate || cmd.add_delta || cmd.clamp, !req_ready, "ready while busy")

   // An accepted update word blocks the input on the next cycle
   `SPY_ASSERT_NEXT(a_update_blocks, req_valid && req_ready && !req_is_load, !req_ready && cmd.mul_dt, "update did not start")

   // A load word raises no result
   `SPY_ASSERT_NEXT(a_load_silent, req_valid && req_ready && req_is_load && !rsp_valid, !rsp_valid, "load produced a result")

endmodule

`default_nettype wire
